@@ rtl/k_permutation_generator_core_assert.svh @@
`ifndef K_PERMUTATION_GENERATOR_CORE_ASSERT_SVH
`define K_PERMUTATION_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication
`define KPG_ASSERT_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("kpg check failed");

// next-cycle implication
`define KPG_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("kpg check failed");

`endif

@@ rtl/kpg_pkg.sv @@
package kpg_pkg;

  localparam int MAX_SET_DEF  = 16;
  localparam int MAX_PICK_DEF = 8;

  localparam int SET_SIZE_W = 5;
  localparam int PICK_W     = 4;
  localparam int ARR_W      = 32;
  localparam int SLOT_W     = 4;
  localparam int SLOTS      = ARR_W / SLOT_W;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT = CFG_IDX_W'(1);

  localparam logic [SET_SIZE_W-1:0] SET_SIZE_RST = SET_SIZE_W'(4);
  localparam logic [PICK_W-1:0]     PICK_RST     = PICK_W'(3);

  typedef struct packed {
    logic subset_done;
    logic all_done;
  } kpg_flags_t;

endpackage

@@ rtl/kpg_if.sv @@
interface kpg_req_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface kpg_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [kpg_pkg::ARR_W-1:0]   arrangement;
  logic                        subset_done;
  logic                        all_done;
  modport source (output valid, output arrangement, output subset_done, output all_done,
                  input ready);
  modport sink (input valid, input arrangement, input subset_done, input all_done,
                output ready);
endinterface

interface kpg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [kpg_pkg::CFG_IDX_W-1:0]   index;
  logic [kpg_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/kpg_sjt.sv @@
module kpg_sjt #(
  parameter int MAX_SET  = kpg_pkg::MAX_SET_DEF,
  parameter int MAX_PICK = kpg_pkg::MAX_PICK_DEF,
  localparam int IDX_W   = (MAX_SET > 1) ? $clog2(MAX_SET) : 1
) (
  input  logic [kpg_pkg::PICK_W-1:0]      k,
  input  logic [MAX_PICK-1:0][IDX_W-1:0]  order,
  input  logic [MAX_PICK-1:0]             heading_left,
  output logic                            found,
  output logic [MAX_PICK-1:0][IDX_W-1:0]  order_next,
  output logic [MAX_PICK-1:0]             heading_next
);

  logic [MAX_PICK-1:0]            active;
  logic [MAX_PICK-1:0]            mob;
  logic [MAX_PICK-1:0]            best;
  logic [MAX_PICK-1:0][IDX_W-1:0] prev_ord;
  logic [MAX_PICK-1:0][IDX_W-1:0] next_ord;
  logic [MAX_PICK-1:0]            prev_hl;
  logic [MAX_PICK-1:0]            next_hl;
  logic [MAX_PICK-1:0]            has_prev;
  logic [MAX_PICK-1:0]            has_next;
  logic [MAX_PICK-1:0]            prev_best;
  logic [MAX_PICK-1:0]            next_best;
  logic [MAX_PICK-1:0][IDX_W-1:0] ord_sw;
  logic [MAX_PICK-1:0]            hl_sw;
  logic [IDX_W-1:0]               moved;

  // neighbor taps; the edge slots see none
  for (genvar i = 0; i < MAX_PICK; i++) begin : g_nb
    assign active[i] = int'(k) > i;
    if (i > 0) begin : g_prev
      assign prev_ord[i]  = order[i-1];
      assign prev_hl[i]   = heading_left[i-1];
      assign prev_best[i] = best[i-1];
      assign has_prev[i]  = 1'b1;
    end else begin : g_noprev
      assign prev_ord[i]  = '0;
      assign prev_hl[i]   = 1'b0;
      assign prev_best[i] = 1'b0;
      assign has_prev[i]  = 1'b0;
    end
    if (i < MAX_PICK - 1) begin : g_next
      assign next_ord[i]  = order[i+1];
      assign next_hl[i]   = heading_left[i+1];
      assign next_best[i] = best[i+1];
      assign has_next[i]  = active[i+1];
    end else begin : g_nonext
      assign next_ord[i]  = '0;
      assign next_hl[i]   = 1'b0;
      assign next_best[i] = 1'b0;
      assign has_next[i]  = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_PICK; i++) begin
      if (heading_left[i]) begin
        mob[i] = active[i] && has_prev[i] && (order[i] > prev_ord[i]);
      end else begin
        mob[i] = active[i] && has_next[i] && (order[i] > next_ord[i]);
      end
    end
  end

  // values among the first k are distinct, so at most one mobile slot (the largest) wins
  always_comb begin
    for (int i = 0; i < MAX_PICK; i++) begin
      best[i] = mob[i];
      for (int j = 0; j < MAX_PICK; j++) begin
        if (j != i && mob[j] && order[j] > order[i]) begin
          best[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    moved = '0;
    for (int i = 0; i < MAX_PICK; i++) begin
      if (best[i]) begin
        moved = moved | order[i];
      end
    end
  end

  assign found = |best;

  always_comb begin
    for (int i = 0; i < MAX_PICK; i++) begin
      ord_sw[i] = order[i];
      hl_sw[i]  = heading_left[i];
      if (best[i]) begin
        if (heading_left[i]) begin
          ord_sw[i] = prev_ord[i];
          hl_sw[i]  = prev_hl[i];
        end else begin
          ord_sw[i] = next_ord[i];
          hl_sw[i]  = next_hl[i];
        end
      end
      if (next_best[i] && next_hl[i]) begin
        ord_sw[i] = next_ord[i];
        hl_sw[i]  = next_hl[i];
      end
      if (prev_best[i] && !prev_hl[i]) begin
        ord_sw[i] = prev_ord[i];
        hl_sw[i]  = prev_hl[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_PICK; i++) begin
      order_next[i]   = ord_sw[i];
      heading_next[i] = hl_sw[i] ^ (active[i] && (ord_sw[i] > moved));
    end
  end

endmodule

@@ rtl/kpg_subset.sv @@
module kpg_subset #(
  parameter int MAX_SET  = kpg_pkg::MAX_SET_DEF,
  parameter int MAX_PICK = kpg_pkg::MAX_PICK_DEF,
  localparam int IDX_W   = (MAX_SET > 1) ? $clog2(MAX_SET) : 1,
  localparam int NW      = $clog2(MAX_SET + 1)
) (
  input  logic [MAX_SET-1:0]              mask,
  input  logic [NW-1:0]                   n_eff,
  output logic                            ok,
  output logic [MAX_SET-1:0]              mask_next,
  output logic [MAX_PICK-1:0][IDX_W-1:0]  order_load
);

  localparam int MW = MAX_SET + 1;
  localparam int CW = $clog2(MAX_SET + 1);

  logic [MW-1:0]              x;
  logic [MW-1:0]              c;
  logic [MW-1:0]              r;
  logic [MW-1:0]              t;
  logic [MW-1:0]              nx;
  logic [IDX_W-1:0]           tz;
  logic [MAX_SET-1:0][CW-1:0] cnt;

  // next mask with the same popcount: lowest run moves up, remainder refills at bit 0
  always_comb begin
    tz = '0;
    for (int j = MAX_SET - 1; j >= 0; j--) begin
      if (mask[j]) begin
        tz = IDX_W'(j);
      end
    end
  end

  assign x  = MW'(mask);
  assign c  = x & (~x + MW'(1));
  assign r  = x + c;
  assign t  = ((r ^ x) >> 2) >> tz;
  assign nx = t | r;
  assign ok = (mask != '0) && ((nx >> n_eff) == '0);
  assign mask_next = nx[MAX_SET-1:0];

  always_comb begin
    for (int j = 0; j < MAX_SET; j++) begin
      cnt[j] = CW'($countones(nx[MAX_SET-1:0] & MAX_SET'((MW'(1) << j) - MW'(1))));
    end
  end

  always_comb begin
    for (int p = 0; p < MAX_PICK; p++) begin
      order_load[p] = '0;
      for (int j = 0; j < MAX_SET; j++) begin
        if (nx[j] && int'(cnt[j]) == p) begin
          order_load[p] = order_load[p] | IDX_W'(j);
        end
      end
    end
  end

endmodule

@@ rtl/k_permutation_generator_core.sv @@
// channel | role | word
// req     | sink | restart (1 = first arrangement, 0 = advance)
// rsp     | src  | arrangement, subset_done, all_done
// cfg     | sink | index, data (set_size, pick_count)
//
// One advance per cycle while req is not stalled; each taken word's result is registered.
// The state registers feed the mobile search and next-subset step each cycle.
// A result waits in a staging flag, then in the output register; req stalls only
// when both hold a word and rsp is not ready.
// Synchronous reset: n = 4, k = 3, nothing started.
`include "k_permutation_generator_core_assert.svh"

module k_permutation_generator_core #(
  parameter int MAX_SET  = kpg_pkg::MAX_SET_DEF,
  parameter int MAX_PICK = kpg_pkg::MAX_PICK_DEF
) (
  input logic       clk,
  input logic       rst,
  kpg_req_if.sink   req,
  kpg_rsp_if.source rsp,
  kpg_cfg_if.sink   cfg
);

  localparam int IDX_W = (MAX_SET > 1) ? $clog2(MAX_SET) : 1;
  localparam int NW    = $clog2(MAX_SET + 1);

  logic [kpg_pkg::SET_SIZE_W-1:0] set_size;
  logic [kpg_pkg::PICK_W-1:0]     pick_count;
  logic [MAX_SET-1:0]             subset_mask;
  logic [MAX_PICK-1:0][IDX_W-1:0] order;
  logic [MAX_PICK-1:0]            heading_left;
  logic                           started;
  logic                           finished;
  logic                           fresh;
  logic                           rsp_valid;
  logic [kpg_pkg::ARR_W-1:0]      arrangement;
  kpg_pkg::kpg_flags_t            flags;

  logic [NW-1:0]                  n_eff;
  logic                           k_ok;
  logic                           found;
  logic [MAX_PICK-1:0][IDX_W-1:0] sjt_order;
  logic [MAX_PICK-1:0]            sjt_heading;
  logic                           next_ok;
  logic [MAX_SET-1:0]             next_mask;
  logic [MAX_PICK-1:0][IDX_W-1:0] load_order;
  logic [MAX_SET-1:0]             first_mask;
  logic [MAX_PICK-1:0][IDX_W-1:0] first_order;
  logic [kpg_pkg::SLOTS-1:0][kpg_pkg::SLOT_W-1:0] slots;
  logic                           req_fire;
  logic                           cfg_fire;
  logic                           stage_move;
  logic                           gives_result;
  logic                           start_take;

  kpg_sjt #(.MAX_SET(MAX_SET), .MAX_PICK(MAX_PICK)) u_sjt (
    .k            (pick_count),
    .order        (order),
    .heading_left (heading_left),
    .found        (found),
    .order_next   (sjt_order),
    .heading_next (sjt_heading)
  );

  kpg_subset #(.MAX_SET(MAX_SET), .MAX_PICK(MAX_PICK)) u_subset (
    .mask       (subset_mask),
    .n_eff      (n_eff),
    .ok         (next_ok),
    .mask_next  (next_mask),
    .order_load (load_order)
  );

  assign n_eff = (int'(set_size) > MAX_SET) ? NW'(MAX_SET) : NW'(set_size);
  assign k_ok  = (pick_count != '0) && (int'(pick_count) <= MAX_PICK)
              && (int'(pick_count) <= int'(n_eff));

  always_comb begin
    for (int j = 0; j < MAX_SET; j++) begin
      first_mask[j] = j < int'(pick_count);
    end
    for (int i = 0; i < MAX_PICK; i++) begin
      first_order[i] = (i < int'(pick_count)) ? IDX_W'(i) : '0;
    end
  end

  for (genvar i = 0; i < kpg_pkg::SLOTS; i++) begin : g_slot
    if (i < MAX_PICK) begin : g_used
      assign slots[i] = (i < int'(pick_count)) ? kpg_pkg::SLOT_W'(order[i]) : '0;
    end else begin : g_unused
      assign slots[i] = '0;
    end
  end

  assign stage_move = fresh && (!rsp_valid || rsp.ready);
  assign req.ready  = !fresh || !rsp_valid || rsp.ready;
  assign req_fire   = req.valid && req.ready;
  assign cfg.ready  = 1'b1;
  assign cfg_fire   = cfg.valid;
  assign start_take = req_fire && k_ok && (req.restart || !started);

  always_comb begin
    gives_result = 1'b0;
    if (k_ok) begin
      if (req.restart || !started) begin
        gives_result = 1'b1;
      end else if (!finished) begin
        gives_result = found || next_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_size     <= kpg_pkg::SET_SIZE_RST;
      pick_count   <= kpg_pkg::PICK_RST;
      subset_mask  <= '0;
      order        <= '0;
      heading_left <= '1;
      started      <= 1'b0;
      finished     <= 1'b0;
      fresh        <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_fire) begin
        case (cfg.index)
          kpg_pkg::REG_SET_SIZE: begin
            set_size <= cfg.data[kpg_pkg::SET_SIZE_W-1:0];
            started  <= 1'b0;
            finished <= 1'b0;
          end
          kpg_pkg::REG_PICK_COUNT: begin
            pick_count <= cfg.data[kpg_pkg::PICK_W-1:0];
            started    <= 1'b0;
            finished   <= 1'b0;
          end
          default: ;
        endcase
      end
      if (req_fire) begin
        if (!k_ok) begin
          started  <= 1'b0;
          finished <= 1'b0;
        end else if (req.restart || !started) begin
          subset_mask  <= first_mask;
          order        <= first_order;
          heading_left <= '1;
          started      <= 1'b1;
          finished     <= 1'b0;
        end else if (!finished) begin
          if (found) begin
            order        <= sjt_order;
            heading_left <= sjt_heading;
          end else if (next_ok) begin
            subset_mask  <= next_mask;
            order        <= load_order;
            heading_left <= '1;
          end else begin
            finished <= 1'b1;
          end
        end
      end
      if (req_fire) begin
        fresh <= gives_result;
      end else if (stage_move) begin
        fresh <= 1'b0;
      end
      if (stage_move) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_move) begin
      arrangement       <= slots;
      flags.subset_done <= !found;
      flags.all_done    <= !found && !next_ok;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.arrangement = arrangement;
  assign rsp.subset_done = flags.subset_done;
  assign rsp.all_done    = flags.all_done;

  `KPG_ASSERT_NOW(a_no_overrun, fresh && rsp_valid && !rsp.ready, !req.ready)
  `KPG_ASSERT_NOW(a_finished_started, finished, started)
  `KPG_ASSERT_NOW(a_mask_popcount, started, $countones(subset_mask) == int'(pick_count))
  `KPG_ASSERT_NEXT(a_restart_emits, start_take, fresh && started && !finished)

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import kpg_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [ARR_W-1:0] arr;
    kpg_flags_t       flags;
  } arr_word_t;

  logic clk;
  logic rst = 1'b1;

  kpg_req_if req_ch ();
  kpg_rsp_if rsp_ch ();
  kpg_cfg_if cfg_ch ();

  k_permutation_generator_core uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // generator shadow state
  logic [SET_SIZE_W-1:0] set_reg  = SET_SIZE_RST;
  logic [PICK_W-1:0]     pick_reg = PICK_RST;
  logic [63:0]           cur_mask = '0;
  int                    slot_idx [SLOTS];
  bit                    heading  [SLOTS];
  bit                    gen_started  = 1'b0;
  bit                    gen_finished = 1'b0;

  arr_word_t arrangements_due [$];
  bit        restart_pending  [$];
  int        words_queued = 0;
  int        words_taken  = 0;
  int        items_used   = 0;
  int        err_cnt      = 0;
  int        hold_req     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_n();
    return (set_reg > 16) ? 16 : set_reg;
  endfunction

  function automatic bit pick_ok();
    return pick_reg >= 1 && pick_reg <= SLOTS && pick_reg <= eff_n();
  endfunction

  function automatic bit succ_mask(input logic [63:0] x, output logic [63:0] nx);
    logic [63:0] c;
    logic [63:0] r;
    int          tz;
    nx = '0;
    if (x == 0) return 1'b0;
    c  = x & (~x + 64'd1);
    tz = 0;
    while (c[tz] == 1'b0) tz++;
    r  = x + c;
    nx = ((r ^ x) >> (2 + tz)) | r;
    return nx < (64'd1 << eff_n());
  endfunction

  function automatic void fill_slots(input logic [63:0] mask);
    int p;
    p = 0;
    for (int j = 0; j < SLOTS; j++) begin
      slot_idx[j] = 0;
      heading[j]  = 1'b1;
    end
    for (int j = 0; j < eff_n(); j++) begin
      if (mask[j] && p < SLOTS) begin
        slot_idx[p] = j;
        p++;
      end
    end
  endfunction

  function automatic bit top_mobile(output int pos);
    bit found;
    bit mob;
    int best;
    int k;
    found = 1'b0;
    best  = 0;
    pos   = 0;
    k     = pick_reg;
    for (int i = 0; i < k; i++) begin
      if (heading[i]) mob = i > 0 && slot_idx[i] > slot_idx[i-1];
      else mob = i + 1 < k && slot_idx[i] > slot_idx[i+1];
      if (mob && (!found || slot_idx[i] > best)) begin
        best  = slot_idx[i];
        pos   = i;
        found = 1'b1;
      end
    end
    return found;
  endfunction

  function automatic void post_arrangement();
    arr_word_t   w;
    logic [63:0] nx;
    int          pos;
    w.arr = '0;
    for (int i = 0; i < pick_reg && i < SLOTS; i++)
      w.arr |= ARR_W'(slot_idx[i] & 15) << (SLOT_W * i);
    w.flags.subset_done = !top_mobile(pos);
    w.flags.all_done    = w.flags.subset_done && !succ_mask(cur_mask, nx);
    arrangements_due.insert(arrangements_due.size(), w);
  endfunction

  function automatic void swap_slots(input int a, input int b);
    int v;
    bit h;
    v           = slot_idx[a];
    h           = heading[a];
    slot_idx[a] = slot_idx[b];
    heading[a]  = heading[b];
    slot_idx[b] = v;
    heading[b]  = h;
  endfunction

  function automatic void step_generator(input logic rs);
    int          pos;
    int          moved;
    logic [63:0] nx;
    if (!pick_ok()) begin
      gen_started  = 1'b0;
      gen_finished = 1'b0;
      return;
    end
    if (rs || !gen_started) begin
      cur_mask = (64'd1 << pick_reg) - 64'd1;
      fill_slots(cur_mask);
      gen_started  = 1'b1;
      gen_finished = 1'b0;
      post_arrangement();
      return;
    end
    if (gen_finished) return;
    if (top_mobile(pos)) begin
      if (heading[pos]) begin
        swap_slots(pos, pos - 1);
        pos--;
      end else begin
        swap_slots(pos, pos + 1);
        pos++;
      end
      moved = slot_idx[pos];
      for (int i = 0; i < pick_reg; i++)
        if (slot_idx[i] > moved) heading[i] = !heading[i];
      post_arrangement();
      return;
    end
    if (succ_mask(cur_mask, nx)) begin
      cur_mask = nx;
      fill_slots(cur_mask);
      post_arrangement();
      return;
    end
    gen_finished = 1'b1;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    if (idx == REG_SET_SIZE) set_reg = val[SET_SIZE_W-1:0];
    else if (idx == REG_PICK_COUNT) pick_reg = val[PICK_W-1:0];
    else return;
    gen_started  = 1'b0;
    gen_finished = 1'b0;
  endfunction

  // request driver: bursts with random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid   <= 1'b0;
      req_ch.restart <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        step_generator(req_ch.restart);
        words_taken++;
      end
      if (!(req_ch.valid && !req_ch.ready)) begin
        if (gap_left != 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (restart_pending.size() != 0) begin
          req_ch.valid   <= 1'b1;
          req_ch.restart <= restart_pending.pop_front();
          if (burst_left == 0) burst_left = $urandom_range(1, 24);
          burst_left--;
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and ready pattern
  int hold_ack  = 0;
  int hold_left = 0;
  int ready_pct = 100;
  int pct_left  = 0;

  always @(posedge clk) begin
    arr_word_t w;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (arrangements_due.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected word: arr=%h sd=%b ad=%b", rsp_ch.arrangement,
                     rsp_ch.subset_done, rsp_ch.all_done);
        end else begin
          w = arrangements_due.pop_front();
          if (rsp_ch.arrangement !== w.arr || rsp_ch.subset_done !== w.flags.subset_done ||
              rsp_ch.all_done !== w.flags.all_done) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: exp arr=%h sd=%b ad=%b, got arr=%h sd=%b ad=%b",
                       w.arr, w.flags.subset_done, w.flags.all_done, rsp_ch.arrangement,
                       rsp_ch.subset_done, rsp_ch.all_done);
          end
        end
      end
      if (hold_ack != hold_req) begin
        hold_ack  = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (pct_left == 0) begin
          case ($urandom_range(0, 3))
            0: ready_pct = 100;
            1: ready_pct = 75;
            2: ready_pct = 50;
            default: ready_pct = 25;
          endcase
          pct_left = $urandom_range(16, 96);
        end
        pct_left--;
        rsp_ch.ready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  // watchdog on handshake activity
  int quiet = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg(idx, val);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_size(input int n);
    write_reg(REG_SET_SIZE, {3'($urandom_range(0, 7)), 5'(n)});
  endtask

  task automatic write_pick(input int k);
    write_reg(REG_PICK_COUNT, {4'($urandom_range(0, 15)), 4'(k)});
  endtask

  function automatic void push_word(input bit rs);
    restart_pending.insert(restart_pending.size(), rs);
    words_queued++;
  endfunction

  function automatic void queue_words(input int cnt, input int restart_pct);
    for (int i = 0; i < cnt; i++) push_word($urandom_range(0, 99) < restart_pct);
  endfunction

  task automatic wait_drained();
    do @(posedge clk); while (words_taken != words_queued || arrangements_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int n;
    int k;
    int cnt;
    int pct;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= '0;
    cfg_ch.data    <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // default n=4 k=3: first advance starts, restart mid-way
    push_word(0); push_word(0); push_word(0); push_word(1); push_word(0);
    wait_drained();
    // unknown register index leaves the sequence running
    write_reg(CFG_IDX_W'(7), 8'hFF);
    push_word(0); push_word(0);
    wait_drained();
    // n=3 k=2 run to exhaustion, then restart
    write_reg(REG_SET_SIZE, 8'hE3);
    write_reg(REG_PICK_COUNT, 8'hF2);
    repeat (8) push_word(0);
    push_word(1);
    wait_drained();
    // unusable picks
    write_pick(0);
    push_word(0); push_word(1);
    wait_drained();
    write_pick(15);
    push_word(0);
    wait_drained();
    write_size(2);
    write_pick(3);
    push_word(1);
    wait_drained();
    // oversized n is clamped, widest pick
    write_size(31);
    write_pick(8);
    push_word(0); push_word(0);
    wait_drained();
    // single element set
    write_size(1);
    write_pick(1);
    push_word(0); push_word(0); push_word(0);
    wait_drained();

    // receiver holds off while the sender keeps going, then sender pauses
    write_size(8);
    write_pick(4);
    queue_words(40, 0);
    hold_req <= hold_req + 1;
    wait_drained();
    queue_words(40, 5);
    wait_drained();
    items_used = 80;

    while (items_used < 1650) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          n = $urandom_range(2, 6);
          k = $urandom_range(1, n);
          if ($urandom_range(0, 1)) begin
            write_size(n);
            write_pick(k);
          end else begin
            write_pick(k);
            write_size(n);
          end
        end
        6: begin
          case ($urandom_range(0, 3))
            0: n = 0;
            1: n = 1;
            2: n = 16;
            default: n = $urandom_range(17, 31);
          endcase
          case ($urandom_range(0, 3))
            0: k = 0;
            1: k = 1;
            2: k = 8;
            default: k = $urandom_range(9, 15);
          endcase
          write_size(n);
          write_pick(k);
        end
        7: begin
          n = $urandom_range(7, 16);
          write_size(n);
          write_pick($urandom_range(1, 8));
        end
        8: ;
        default: write_reg(CFG_IDX_W'($urandom_range(2, 15)), 8'($urandom));
      endcase
      pct = $urandom_range(0, 1) ? 0 : 5;
      if (pick_ok()) begin
        cnt = $urandom_range(10, 90);
        items_used += cnt;
      end else begin
        cnt = $urandom_range(1, 5);
      end
      queue_words(cnt, pct);
      wait_drained();
    end

    wait_drained();
    repeat (6) @(posedge clk);
    err_cnt += arrangements_due.size();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
